FILE: rtl/core/mwam_pkg.sv
// ----------------------------------------------------------------------------
// mwam_pkg
// Shared widths, constants and types for the block median measurement unit.
// ----------------------------------------------------------------------------
package mwam_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int OUT_W           = 23;
    localparam int OFFSET_W        = 22;
    localparam int GAIN_W          = 5;
    localparam int SHUNT_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 22;

    localparam int WINDOW_SIZE_DEF = 15;

    localparam int ADC_FULL_MV     = 3300;
    localparam int ADC_MAX_CODE    = 4095;
    localparam int MV_TO_UV        = 1000;
    localparam int OUT_LIMIT       = 3300000;

    // |median - offset| * 3300 fits in 34 bits
    localparam int PROD_W          = 34;
    localparam int Q_W             = 22;
    localparam int RES_W           = 28;
    localparam int DIV_CNT_W       = $clog2(PROD_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEASURE_MODE  = 2'd0,
        CFG_OFFSET_VALUE  = 2'd1,
        CFG_VOLTAGE_GAIN  = 2'd2,
        CFG_SHUNT_DIVISOR = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                measure_mode;
        logic [OFFSET_W-1:0] offset_value;
        logic [GAIN_W-1:0]   voltage_gain;
        logic [SHUNT_W-1:0]  shunt_divisor;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  dividend;
        logic [SHUNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        CALC_IDLE,
        CALC_PREP,
        CALC_FOLD1,
        CALC_FOLD2,
        CALC_VMUL,
        CALC_CMUL,
        CALC_DIV2,
        CALC_WAIT2,
        CALC_SAT,
        CALC_OUT
    } calc_state_t;

endpackage

FILE: rtl/core/mwam_cell.sv
// ----------------------------------------------------------------------------
// mwam_cell
// One slot of the insertion sorting row. Holds a sample and a valid flag and
// takes either the new request or its left neighbor's value on insertion.
// ----------------------------------------------------------------------------
module mwam_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          clear,
    input  logic [mwam_pkg::SAMPLE_W-1:0] sample,
    input  logic [mwam_pkg::SAMPLE_W-1:0] left_val,
    input  logic                          left_shift,
    input  logic                          left_valid,
    output logic [mwam_pkg::SAMPLE_W-1:0] val,
    output logic                          valid,
    output logic                          shift,
    output logic [mwam_pkg::SAMPLE_W-1:0] ins_val
);

    logic [mwam_pkg::SAMPLE_W-1:0] val_reg;
    logic [mwam_pkg::SAMPLE_W-1:0] val_next;
    logic                          valid_reg;
    logic                          valid_next;

    always_comb
    begin
        shift      = !valid_reg || (sample < val_reg);
        val_next   = shift ? (left_shift ? left_val : sample) : val_reg;
        valid_next = clear ? 1'b0 : (valid_reg || left_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
        end
    end

    assign val     = val_reg;
    assign valid   = valid_reg;
    assign ins_val = val_next;

endmodule

FILE: rtl/core/mwam_div.sv
// ----------------------------------------------------------------------------
// mwam_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mwam_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mwam_pkg::div_req_t req,
    output mwam_pkg::div_rsp_t rsp
);

    logic                                 busy_reg;
    logic                                 busy_next;
    logic                                 done_reg;
    logic                                 done_next;
    logic [mwam_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [mwam_pkg::DIV_CNT_W-1:0]       cnt_next;
    logic [mwam_pkg::SHUNT_W-1:0]         rem_reg;
    logic [mwam_pkg::SHUNT_W-1:0]         rem_next;
    logic [mwam_pkg::PROD_W-1:0]          dq_reg;
    logic [mwam_pkg::PROD_W-1:0]          dq_next;
    logic [mwam_pkg::SHUNT_W-1:0]         dvs_reg;
    logic [mwam_pkg::SHUNT_W-1:0]         dvs_next;
    logic [mwam_pkg::SHUNT_W+1:0]         trial;
    logic                                 fits;

    always_comb
    begin
        trial     = {1'b0, rem_reg, dq_reg[mwam_pkg::PROD_W-1]} - {2'b00, dvs_reg};
        fits      = !trial[mwam_pkg::SHUNT_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = mwam_pkg::DIV_CNT_W'(mwam_pkg::PROD_W);
            rem_next  = '0;
            dq_next   = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[mwam_pkg::SHUNT_W-1:0]
                            : {rem_reg[mwam_pkg::SHUNT_W-2:0],
                               dq_reg[mwam_pkg::PROD_W-1]};
            dq_next  = {dq_reg[mwam_pkg::PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mwam_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

FILE: rtl/core/mwam_calc.sv
// ----------------------------------------------------------------------------
// mwam_calc
// Converts a window median into millivolts or microamps, with saturation,
// and holds the result in an output register until taken.
// ----------------------------------------------------------------------------
module mwam_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mwam_pkg::cfg_t                cfg,
    input  logic                          start,
    input  logic [mwam_pkg::SAMPLE_W-1:0] median,
    output logic                          ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mwam_pkg::OUT_W-1:0]    measured
);

    localparam int PW = mwam_pkg::PROD_W;
    localparam int QW = mwam_pkg::Q_W;
    localparam int RW = mwam_pkg::RES_W;
    localparam int SH = mwam_pkg::SAMPLE_W;
    localparam int YW = QW + 1;
    localparam int LW = SH + 1;
    localparam logic signed [RW-1:0] LIM_POS = RW'(mwam_pkg::OUT_LIMIT);
    localparam logic signed [RW-1:0] LIM_NEG = -RW'(mwam_pkg::OUT_LIMIT);

    mwam_pkg::calc_state_t state_reg;
    mwam_pkg::calc_state_t state_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mwam_pkg::SAMPLE_W-1:0] med_reg;
    logic [mwam_pkg::SAMPLE_W-1:0] med_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic [PW-1:0]                 prod_reg;
    logic [PW-1:0]                 prod_next;
    logic [QW-1:0]                 q_reg;
    logic [QW-1:0]                 q_next;
    logic signed [RW-1:0]          res_reg;
    logic signed [RW-1:0]          res_next;
    logic [mwam_pkg::OUT_W-1:0]    out_reg;
    logic [mwam_pkg::OUT_W-1:0]    out_next;

    logic signed [23:0]            diff;
    logic [23:0]                   diff_abs;
    logic [QW-1:0]                 mag;
    logic signed [RW-1:0]          sq;
    logic signed [RW-1:0]          gain_ext;
    logic signed [RW-1:0]          ua_diff;
    logic [YW-1:0]                 fold_sum;
    logic [LW-1:0]                 fold_low;
    logic                          fold_carry;

    mwam_pkg::div_req_t div_req;
    mwam_pkg::div_rsp_t div_rsp;

    mwam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        diff     = $signed({12'b0, med_reg}) - $signed({2'b0, cfg.offset_value});
        diff_abs = diff[23] ? 24'(-diff) : 24'(diff);
        mag      = cfg.measure_mode ? QW'(med_reg) : diff_abs[QW-1:0];
        sq       = neg_reg ? -$signed(RW'(q_reg)) : $signed(RW'(q_reg));
        gain_ext = $signed(RW'(cfg.voltage_gain));
        ua_diff  = $signed(RW'(div_rsp.quotient[QW-1:0]))
                 - $signed(RW'(cfg.offset_value));

        // 4095 = 2^12 - 1: x / 4095 = (x >> 12) + ((x >> 12) + x[11:0]) / 4095,
        // folded twice, the last fold leaves a quotient of 0 or 1
        fold_sum   = YW'(prod_reg[PW-1:SH]) + YW'(prod_reg[SH-1:0]);
        fold_low   = LW'(prod_reg[YW-1:SH]) + LW'(prod_reg[SH-1:0]);
        fold_carry = (fold_low >= LW'(mwam_pkg::ADC_MAX_CODE));

        div_req.start    = (state_reg == mwam_pkg::CALC_DIV2);
        div_req.dividend = prod_reg;
        div_req.divisor  = (cfg.shunt_divisor == '0) ? mwam_pkg::SHUNT_W'(1)
                                                     : cfg.shunt_divisor;

        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        med_next       = med_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        unique case (state_reg)
            mwam_pkg::CALC_IDLE:
            begin
                if (start)
                begin
                    med_next   = median;
                    state_next = mwam_pkg::CALC_PREP;
                end
            end
            mwam_pkg::CALC_PREP:
            begin
                neg_next   = !cfg.measure_mode && diff[23];
                prod_next  = PW'(mag) * PW'(mwam_pkg::ADC_FULL_MV);
                state_next = mwam_pkg::CALC_FOLD1;
            end
            mwam_pkg::CALC_FOLD1:
            begin
                q_next     = prod_reg[PW-1:SH];
                prod_next  = PW'(fold_sum);
                state_next = mwam_pkg::CALC_FOLD2;
            end
            mwam_pkg::CALC_FOLD2:
            begin
                q_next     = q_reg + QW'(prod_reg[YW-1:SH]) + QW'(fold_carry);
                state_next = cfg.measure_mode ? mwam_pkg::CALC_CMUL
                                              : mwam_pkg::CALC_VMUL;
            end
            mwam_pkg::CALC_VMUL:
            begin
                res_next   = sq * gain_ext;
                state_next = mwam_pkg::CALC_SAT;
            end
            mwam_pkg::CALC_CMUL:
            begin
                prod_next  = PW'(q_reg) * PW'(mwam_pkg::MV_TO_UV);
                state_next = mwam_pkg::CALC_DIV2;
            end
            mwam_pkg::CALC_DIV2:
            begin
                state_next = mwam_pkg::CALC_WAIT2;
            end
            mwam_pkg::CALC_WAIT2:
            begin
                if (div_rsp.done)
                begin
                    res_next   = ua_diff[RW-1] ? '0 : ua_diff;
                    state_next = mwam_pkg::CALC_SAT;
                end
            end
            mwam_pkg::CALC_SAT:
            begin
                priority if (res_reg > LIM_POS)
                begin
                    out_next = mwam_pkg::OUT_W'(LIM_POS);
                end
                else if (res_reg < LIM_NEG)
                begin
                    out_next = mwam_pkg::OUT_W'(LIM_NEG);
                end
                else
                begin
                    out_next = res_reg[mwam_pkg::OUT_W-1:0];
                end
                out_valid_next = 1'b1;
                state_next     = mwam_pkg::CALC_OUT;
            end
            mwam_pkg::CALC_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = mwam_pkg::CALC_IDLE;
                end
            end
            default:
            begin
                state_next = mwam_pkg::CALC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwam_pkg::CALC_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg  <= med_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign ready     = (state_reg == mwam_pkg::CALC_IDLE);
    assign out_valid = out_valid_reg;
    assign measured  = out_reg;

endmodule

FILE: rtl/core/median_window_adc_measure.sv
// ----------------------------------------------------------------------------
// median_window_adc_measure
// Block median of 12-bit converter samples, scaled to mV or uA.
//
// Input channel (in_valid / in_stall / sample): one sample per request,
// taken back to back by a row of sorting cells. Samples form non-overlapping
// windows of WINDOW_SIZE; the last sample of a window latches the median and
// clears the row for the next window.
// Output channel (out_valid / out_stall / measured): one result per window;
// in current mode the bit-serial divide by the shunt divisor dominates.
// Filling continues while a result is computed or waits; in_stall is raised
// only on the last sample of a window while the previous result is still
// being computed or held. A stalled output holds its value.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; the user must see that it is written only while the block is idle;
// the block itself does not enforce this. Reset clears the window, the
// pending result and the registers to mode 0, offset 0, gain 1, divisor 1.
// ----------------------------------------------------------------------------
module median_window_adc_measure #(
    parameter int WINDOW_SIZE = mwam_pkg::WINDOW_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mwam_pkg::SAMPLE_W-1:0]   sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [mwam_pkg::OUT_W-1:0] measured,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mwam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwam_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int MID = WINDOW_SIZE / 2;
    localparam logic signed [mwam_pkg::OUT_W-1:0] LIM =
        mwam_pkg::OUT_W'(mwam_pkg::OUT_LIMIT);

    mwam_pkg::cfg_t cfg_reg;
    mwam_pkg::cfg_t cfg_next;

    logic [mwam_pkg::SAMPLE_W-1:0] cell_val   [WINDOW_SIZE];
    logic [mwam_pkg::SAMPLE_W-1:0] cell_ins   [WINDOW_SIZE];
    logic                          cell_shift [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0]        win_valid;

    logic                          in_accept;
    logic                          last;
    logic                          med_start;
    logic                          calc_ready;
    logic [mwam_pkg::OUT_W-1:0]    calc_out;

    assign last      = win_valid[WINDOW_SIZE-2];
    assign in_stall  = last && !calc_ready;
    assign in_accept = in_valid && !in_stall;
    assign med_start = in_accept && last;

    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_cell
        logic [mwam_pkg::SAMPLE_W-1:0] left_val;
        logic                          left_shift;
        logic                          left_valid;

        if (i == 0)
        begin : g_first
            assign left_val   = '0;
            assign left_shift = 1'b0;
            assign left_valid = 1'b1;
        end
        else
        begin : g_rest
            assign left_val   = cell_val[i-1];
            assign left_shift = cell_shift[i-1];
            assign left_valid = win_valid[i-1];
        end

        mwam_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (in_accept),
            .clear      (last),
            .sample     (sample),
            .left_val   (left_val),
            .left_shift (left_shift),
            .left_valid (left_valid),
            .val        (cell_val[i]),
            .valid      (win_valid[i]),
            .shift      (cell_shift[i]),
            .ins_val    (cell_ins[i])
        );
    end

    mwam_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (med_start),
        .median    (cell_ins[MID]),
        .ready     (calc_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .measured  (calc_out)
    );

    assign measured  = $signed(calc_out);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (mwam_pkg::cfg_idx_t'(cfg_index))
                mwam_pkg::CFG_MEASURE_MODE:
                    cfg_next.measure_mode  = cfg_data[0];
                mwam_pkg::CFG_OFFSET_VALUE:
                    cfg_next.offset_value  = cfg_data[mwam_pkg::OFFSET_W-1:0];
                mwam_pkg::CFG_VOLTAGE_GAIN:
                    cfg_next.voltage_gain  = cfg_data[mwam_pkg::GAIN_W-1:0];
                mwam_pkg::CFG_SHUNT_DIVISOR:
                    cfg_next.shunt_divisor = cfg_data[mwam_pkg::SHUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.measure_mode  <= 1'b0;
            cfg_reg.offset_value  <= '0;
            cfg_reg.voltage_gain  <= mwam_pkg::GAIN_W'(1);
            cfg_reg.shunt_divisor <= mwam_pkg::SHUNT_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // occupied cells always form a prefix of the row
    a_fill_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((win_valid + 1'b1) & win_valid) == '0)
        else $error("sorting row occupancy is not contiguous");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        med_start |-> calc_ready)
        else $error("median latched while converter unit busy");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (measured <= LIM) && (measured >= -LIM))
        else $error("result outside saturation range");

    a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result delivered twice");

endmodule
